/* hdl/pfs_pkg.sv */
// Shared types and constants for the potential-field navigation step.
// Used by pfs_ctrl, pfs_datapath and potential_field_step; no dependencies.
package pfs_pkg;

  localparam int HugePush = 1000000;

  localparam int PosW   = 20;
  localparam int DiffW  = PosW + 1;
  localparam int DistW  = 21;
  localparam int RadW   = 16;
  localparam int GainW  = 12;
  localparam int MagW   = 29;
  localparam int QuotW  = 22;
  localparam int ForceW = 24;
  localparam int SumW   = 32;
  localparam int SqW    = 43;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;
  localparam int SqrtSteps = 22;

  localparam logic [CfgIdxW-1:0] CFG_GOAL_X        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GOAL_Y        = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GOAL_RADIUS   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GOAL_SPREAD   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GOAL_GAIN     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OBSTACLE_GAIN = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MAX_STEP      = 3'd6;

  localparam logic [1:0] ST_MOVED   = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_ARRIVED = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETOBS,
    OP_SETGOAL,
    OP_SQ,
    OP_SQRT,
    OP_CLASS,
    OP_MUL,
    OP_DIV,
    OP_STORE,
    OP_ACC,
    OP_FX2,
    OP_FY2,
    OP_CMP,
    OP_MOVE,
    OP_ARR
  } op_e;

  typedef struct packed {
    op_e  op;
    logic axis_y;
  } cmd_t;

  typedef struct packed {
    logic skip_div;
  } stat_t;

endpackage

/* hdl/pfs_ctrl.sv */
// Sequencer for the potential-field step: issues datapath commands.
// Depends on pfs_pkg.
module pfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          mode_i,
  input  logic          last_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pfs_pkg::cmd_t cmd_o,
  input  pfs_pkg::stat_t stat_i
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQ    = 5'd1;
  localparam logic [4:0] S_SQRT  = 5'd2;
  localparam logic [4:0] S_CLASS = 5'd3;
  localparam logic [4:0] S_MULX  = 5'd4;
  localparam logic [4:0] S_DIVX  = 5'd5;
  localparam logic [4:0] S_STX   = 5'd6;
  localparam logic [4:0] S_MULY  = 5'd7;
  localparam logic [4:0] S_DIVY  = 5'd8;
  localparam logic [4:0] S_STY   = 5'd9;
  localparam logic [4:0] S_ACC   = 5'd10;
  localparam logic [4:0] S_SETG  = 5'd11;
  localparam logic [4:0] S_FX2   = 5'd12;
  localparam logic [4:0] S_FY2   = 5'd13;
  localparam logic [4:0] S_CMP   = 5'd14;
  localparam logic [4:0] S_MOVE  = 5'd15;
  localparam logic [4:0] S_ARR   = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  localparam logic [4:0] LastStep = 5'(pfs_pkg::SqrtSteps - 1);
  localparam logic [4:0] LastDiv  = 5'(pfs_pkg::QuotW - 1);

  logic [4:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic       goal_q, goal_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      goal_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      goal_q  <= goal_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    goal_d      = goal_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.op     = pfs_pkg::OP_NONE;
    cmd_o.axis_y = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!mode_i) begin
            cmd_o.op = pfs_pkg::OP_LOAD;
          end else begin
            cmd_o.op = pfs_pkg::OP_SETOBS;
            last_d   = last_i;
            goal_d   = 1'b0;
            state_d  = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd_o.op = pfs_pkg::OP_SQ;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = pfs_pkg::OP_SQRT;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == LastStep) begin
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd_o.op = pfs_pkg::OP_CLASS;
        state_d  = S_MULX;
      end
      S_MULX: begin
        cmd_o.op = pfs_pkg::OP_MUL;
        cnt_d    = '0;
        state_d  = stat_i.skip_div ? S_ACC : S_DIVX;
      end
      S_DIVX: begin
        cmd_o.op = pfs_pkg::OP_DIV;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == LastDiv) begin
          state_d = S_STX;
        end
      end
      S_STX: begin
        cmd_o.op = pfs_pkg::OP_STORE;
        state_d  = S_MULY;
      end
      S_MULY: begin
        cmd_o.op     = pfs_pkg::OP_MUL;
        cmd_o.axis_y = 1'b1;
        cnt_d        = '0;
        state_d      = S_DIVY;
      end
      S_DIVY: begin
        cmd_o.op = pfs_pkg::OP_DIV;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == LastDiv) begin
          state_d = S_STY;
        end
      end
      S_STY: begin
        cmd_o.op     = pfs_pkg::OP_STORE;
        cmd_o.axis_y = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = pfs_pkg::OP_ACC;
        if (goal_q) begin
          state_d = S_FX2;
        end else if (last_q) begin
          state_d = S_SETG;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SETG: begin
        cmd_o.op = pfs_pkg::OP_SETGOAL;
        goal_d   = 1'b1;
        state_d  = S_SQ;
      end
      S_FX2: begin
        cmd_o.op = pfs_pkg::OP_FX2;
        state_d  = S_FY2;
      end
      S_FY2: begin
        cmd_o.op = pfs_pkg::OP_FY2;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = pfs_pkg::OP_CMP;
        state_d  = S_MOVE;
      end
      S_MOVE: begin
        cmd_o.op = pfs_pkg::OP_MOVE;
        state_d  = S_ARR;
      end
      S_ARR: begin
        cmd_o.op = pfs_pkg::OP_ARR;
        state_d  = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/pfs_datapath.sv */
// Datapath for the potential-field step: config registers, robot state,
// iterative square root, shared restoring divider, force sums. Depends on pfs_pkg.
module pfs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pfs_pkg::cmd_t                        cmd_i,
  output pfs_pkg::stat_t                       stat_o,
  input  logic                                 cfg_we_i,
  input  logic [pfs_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [pfs_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic signed [pfs_pkg::PosW-1:0]      pos_x_i,
  input  logic signed [pfs_pkg::PosW-1:0]      pos_y_i,
  input  logic [pfs_pkg::RadW-1:0]             obstacle_radius_i,
  input  logic [pfs_pkg::RadW-1:0]             obstacle_spread_i,
  output logic signed [pfs_pkg::PosW-1:0]      new_x_o,
  output logic signed [pfs_pkg::PosW-1:0]      new_y_o,
  output logic [1:0]                           status_o
);

  localparam int PosW   = pfs_pkg::PosW;
  localparam int DiffW  = pfs_pkg::DiffW;
  localparam int DistW  = pfs_pkg::DistW;
  localparam int RadW   = pfs_pkg::RadW;
  localparam int GainW  = pfs_pkg::GainW;
  localparam int MagW   = pfs_pkg::MagW;
  localparam int QuotW  = pfs_pkg::QuotW;
  localparam int ForceW = pfs_pkg::ForceW;
  localparam int SumW   = pfs_pkg::SumW;
  localparam int SqW    = pfs_pkg::SqW;
  localparam int DivW   = DistW + 8;
  localparam int ProdW  = MagW + DiffW;

  localparam logic signed [ForceW-1:0] Huge = ForceW'(pfs_pkg::HugePush);
  localparam logic signed [SumW:0] SumMax = {2'b00, {(SumW-1){1'b1}}};
  localparam logic signed [SumW:0] SumMin = {2'b11, {(SumW-1){1'b0}}};
  localparam logic signed [SumW:0] PosMax = (SumW+1)'((1 <<< (PosW-1)) - 1);
  localparam logic signed [SumW:0] PosMin = -(SumW+1)'(1 <<< (PosW-1));

  logic signed [PosW-1:0]  goal_x_q, goal_y_q;
  logic [RadW-1:0]         goal_radius_q, goal_spread_q, max_step_q;
  logic [GainW-1:0]        goal_gain_q, obstacle_gain_q;

  logic signed [PosW-1:0]  robot_x_q, robot_y_q;
  logic signed [SumW-1:0]  fsum_x_q, fsum_y_q;

  logic signed [DiffW-1:0] dx_q, dy_q, dxe_q, dye_q;
  logic [RadW-1:0]         rad_q, spr_q;
  logic                    is_goal_q;
  logic [SqW-1:0]          v_q, r_q, bit_q;
  logic [MagW-1:0]         mag_q;
  logic                    skip_q, neg_q;
  logic [DivW-1:0]         div_q;
  logic [DivW-1:0]         rem_q;
  logic [QuotW-1:0]        qsh_q;
  logic signed [ForceW-1:0] fx_q, fy_q;
  logic [63:0]             fsq_q;
  logic                    refused_q;
  logic [1:0]              status_q;

  // combinational helpers
  logic [DiffW-1:0]  abs_dx, abs_dy;
  logic [SqW-1:0]    rb;
  logic [DistW-1:0]  d;
  logic [RadW:0]     lim;
  logic [RadW:0]     depth;
  logic              below, inband;
  logic signed [DiffW-1:0] sel;
  logic [DiffW-1:0]  abs_sel;
  logic [ProdW-1:0]  prod;
  logic [DivW:0]     t;
  logic              neg_res;
  logic signed [ForceW-1:0] qres;
  logic signed [ForceW-1:0] facc;
  logic signed [SumW-1:0]   fsel;
  logic signed [SumW:0]     sum_x, sum_y;
  logic [SumW-1:0]   abs_f;
  logic signed [SumW:0] mvx, mvy;
  logic signed [DiffW-1:0] gdx, gdy;
  logic [DiffW-1:0]  agx, agy;
  logic [SqW-1:0]    gd2;

  always_comb begin
    abs_dx = dx_q[DiffW-1] ? DiffW'(-dx_q) : DiffW'(dx_q);
    abs_dy = dy_q[DiffW-1] ? DiffW'(-dy_q) : DiffW'(dy_q);
    rb     = r_q + bit_q;
    d      = r_q[DistW-1:0];
    lim    = {1'b0, rad_q} + {1'b0, spr_q};
    below  = d < DistW'(rad_q);
    inband = d <= DistW'(lim);
    if (is_goal_q) begin
      depth = inband ? (RadW+1)'(d - DistW'(rad_q)) : {1'b0, spr_q};
    end else begin
      depth = (RadW+1)'(DistW'(lim) - d);
    end
    sel     = cmd_i.axis_y ? dye_q : dxe_q;
    abs_sel = sel[DiffW-1] ? DiffW'(-sel) : DiffW'(sel);
    prod    = ProdW'(mag_q) * ProdW'(abs_sel);
    t       = {rem_q, qsh_q[QuotW-1]};
    neg_res = sel[DiffW-1] ^ neg_q;
    qres    = neg_res ? -$signed(ForceW'(qsh_q)) : $signed(ForceW'(qsh_q));
    sum_x   = $signed({fsum_x_q[SumW-1], fsum_x_q}) + (SumW+1)'(fx_q);
    sum_y   = $signed({fsum_y_q[SumW-1], fsum_y_q}) + (SumW+1)'(fy_q);
    facc    = '0;
    fsel    = (cmd_i.op == pfs_pkg::OP_FY2) ? fsum_y_q : fsum_x_q;
    abs_f   = fsel[SumW-1] ? SumW'(-fsel) : SumW'(fsel);
    mvx     = (SumW+1)'(robot_x_q) + (SumW+1)'(fsum_x_q);
    mvy     = (SumW+1)'(robot_y_q) + (SumW+1)'(fsum_y_q);
    gdx     = DiffW'(goal_x_q) - DiffW'(robot_x_q);
    gdy     = DiffW'(goal_y_q) - DiffW'(robot_y_q);
    agx     = gdx[DiffW-1] ? DiffW'(-gdx) : DiffW'(gdx);
    agy     = gdy[DiffW-1] ? DiffW'(-gdy) : DiffW'(gdy);
    gd2     = SqW'(agx) * SqW'(agx) + SqW'(agy) * SqW'(agy);
    if (facc != '0) begin
      facc = '0;
    end
  end

  assign stat_o.skip_div = skip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q        <= '0;
      goal_y_q        <= '0;
      goal_radius_q   <= RadW'(512);
      goal_spread_q   <= RadW'(512);
      goal_gain_q     <= GainW'(256);
      obstacle_gain_q <= GainW'(384);
      max_step_q      <= RadW'(2560);
      robot_x_q       <= '0;
      robot_y_q       <= '0;
      fsum_x_q        <= '0;
      fsum_y_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pfs_pkg::CFG_GOAL_X:        goal_x_q        <= cfg_data_i;
          pfs_pkg::CFG_GOAL_Y:        goal_y_q        <= cfg_data_i;
          pfs_pkg::CFG_GOAL_RADIUS:   goal_radius_q   <= cfg_data_i[RadW-1:0];
          pfs_pkg::CFG_GOAL_SPREAD:   goal_spread_q   <= cfg_data_i[RadW-1:0];
          pfs_pkg::CFG_GOAL_GAIN:     goal_gain_q     <= cfg_data_i[GainW-1:0];
          pfs_pkg::CFG_OBSTACLE_GAIN: obstacle_gain_q <= cfg_data_i[GainW-1:0];
          pfs_pkg::CFG_MAX_STEP:      max_step_q      <= cfg_data_i[RadW-1:0];
          default: begin
          end
        endcase
      end
      case (cmd_i.op)
        pfs_pkg::OP_LOAD: begin
          robot_x_q <= pos_x_i;
          robot_y_q <= pos_y_i;
          fsum_x_q  <= '0;
          fsum_y_q  <= '0;
        end
        pfs_pkg::OP_ACC: begin
          fsum_x_q <= (sum_x > SumMax) ? SumW'(SumMax) :
                      (sum_x < SumMin) ? SumW'(SumMin) : SumW'(sum_x);
          fsum_y_q <= (sum_y > SumMax) ? SumW'(SumMax) :
                      (sum_y < SumMin) ? SumW'(SumMin) : SumW'(sum_y);
        end
        pfs_pkg::OP_MOVE: begin
          if (!refused_q) begin
            robot_x_q <= (mvx > PosMax) ? PosW'(PosMax) :
                         (mvx < PosMin) ? PosW'(PosMin) : PosW'(mvx);
            robot_y_q <= (mvy > PosMax) ? PosW'(PosMax) :
                         (mvy < PosMin) ? PosW'(PosMin) : PosW'(mvy);
          end
        end
        pfs_pkg::OP_ARR: begin
          fsum_x_q <= '0;
          fsum_y_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      pfs_pkg::OP_SETOBS: begin
        dx_q      <= DiffW'(pos_x_i) - DiffW'(robot_x_q);
        dy_q      <= DiffW'(pos_y_i) - DiffW'(robot_y_q);
        rad_q     <= obstacle_radius_i;
        spr_q     <= obstacle_spread_i;
        is_goal_q <= 1'b0;
      end
      pfs_pkg::OP_SETGOAL: begin
        dx_q      <= DiffW'(goal_x_q) - DiffW'(robot_x_q);
        dy_q      <= DiffW'(goal_y_q) - DiffW'(robot_y_q);
        rad_q     <= goal_radius_q;
        spr_q     <= goal_spread_q;
        is_goal_q <= 1'b1;
      end
      pfs_pkg::OP_SQ: begin
        v_q   <= SqW'(abs_dx) * SqW'(abs_dx) + SqW'(abs_dy) * SqW'(abs_dy);
        r_q   <= '0;
        bit_q <= SqW'(1) << (SqW - 1);
      end
      pfs_pkg::OP_SQRT: begin
        if (v_q >= rb) begin
          v_q <= v_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      pfs_pkg::OP_CLASS: begin
        neg_q <= !is_goal_q;
        mag_q <= MagW'((is_goal_q ? goal_gain_q : obstacle_gain_q)) * MagW'(depth);
        if (d == '0) begin
          dxe_q <= DiffW'(1);
          dye_q <= '0;
          div_q <= DivW'(1) << 8;
        end else begin
          dxe_q <= dx_q;
          dye_q <= dy_q;
          div_q <= {d, 8'b0};
        end
        if (is_goal_q) begin
          skip_q <= below;
          fx_q   <= '0;
          fy_q   <= '0;
        end else begin
          skip_q <= below || !inband;
          fx_q   <= !below ? '0 : ((dx_q > 0) ? -Huge : Huge);
          fy_q   <= !below ? '0 : ((dy_q > 0) ? -Huge : Huge);
        end
      end
      pfs_pkg::OP_MUL: begin
        rem_q <= DivW'(prod[ProdW-1:QuotW]);
        qsh_q <= prod[QuotW-1:0];
      end
      pfs_pkg::OP_DIV: begin
        if (t >= {1'b0, div_q}) begin
          rem_q <= DivW'(t - {1'b0, div_q});
          qsh_q <= {qsh_q[QuotW-2:0], 1'b1};
        end else begin
          rem_q <= DivW'(t);
          qsh_q <= {qsh_q[QuotW-2:0], 1'b0};
        end
      end
      pfs_pkg::OP_STORE: begin
        if (cmd_i.axis_y) begin
          fy_q <= qres + facc;
        end else begin
          fx_q <= qres + facc;
        end
      end
      pfs_pkg::OP_FX2: begin
        fsq_q <= 64'(abs_f) * 64'(abs_f);
      end
      pfs_pkg::OP_FY2: begin
        fsq_q <= fsq_q + 64'(abs_f) * 64'(abs_f);
      end
      pfs_pkg::OP_CMP: begin
        refused_q <= fsq_q > 64'(32'(max_step_q) * 32'(max_step_q));
      end
      pfs_pkg::OP_ARR: begin
        if (refused_q) begin
          status_q <= pfs_pkg::ST_REFUSED;
        end else if (gd2 <= SqW'(32'(goal_radius_q) * 32'(goal_radius_q))) begin
          status_q <= pfs_pkg::ST_ARRIVED;
        end else begin
          status_q <= pfs_pkg::ST_MOVED;
        end
      end
      default: begin
      end
    endcase
  end

  assign new_x_o  = robot_x_q;
  assign new_y_o  = robot_y_q;
  assign status_o = status_q;

endmodule

/* hdl/potential_field_step.sv */
// Top level of the potential-field navigation step.
// Depends on pfs_pkg, pfs_ctrl and pfs_datapath.
//
// A mode-0 item loads the robot position. A mode-1 item runs an iterative square root
// and, when the obstacle lies in its repulsion band, two divisions on one shared
// divider; inside the radius or beyond the band it skips them. An item with last
// set then sets up the goal, repeats this for the goal and runs the step check
// before the result is offered; the next item is taken once that result
// transfers. Configuration writes are always ready.
module potential_field_step (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 mode_i,
  input  logic signed [pfs_pkg::PosW-1:0]      pos_x_i,
  input  logic signed [pfs_pkg::PosW-1:0]      pos_y_i,
  input  logic [pfs_pkg::RadW-1:0]             obstacle_radius_i,
  input  logic [pfs_pkg::RadW-1:0]             obstacle_spread_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pfs_pkg::PosW-1:0]      new_x_o,
  output logic signed [pfs_pkg::PosW-1:0]      new_y_o,
  output logic [1:0]                           status_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pfs_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [pfs_pkg::CfgDataW-1:0]         cfg_data_i
);

  pfs_pkg::cmd_t  cmd;
  pfs_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  pfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  pfs_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .obstacle_radius_i (obstacle_radius_i),
    .obstacle_spread_i (obstacle_spread_i),
    .new_x_o           (new_x_o),
    .new_y_o           (new_y_o),
    .status_o          (status_o)
  );

endmodule
